// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/vnm_pkg.sv
// Shared types and constants of the voxel neighbour mask block.
package vnm_pkg;

  localparam int TYPE_W   = 5;
  localparam int POS_XZ_W = 6;
  localparam int POS_Y_W  = 4;
  localparam int MASK_W   = 27;
  localparam int BIT_W    = 5;

  // bit (dy+1)*9 + (dz+1)*3 + (dx+1); centre is all offsets zero
  localparam logic [BIT_W-1:0] CENTRE_BIT = 5'd13;
  localparam logic [BIT_W-1:0] LAST_BIT   = 5'd26;

  localparam logic [MASK_W-1:0] BOTTOM_RESET = 27'd511;

  // per-axis offset codes
  localparam logic [1:0] OFS_MINUS = 2'd0;
  localparam logic [1:0] OFS_ZERO  = 2'd1;
  localparam logic [1:0] OFS_PLUS  = 2'd2;
  localparam logic [1:0] OFS_NONE  = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [POS_XZ_W-1:0] x;
    logic [POS_Y_W-1:0]  y;
    logic [POS_XZ_W-1:0] z;
  } pos_t;

  // one store access travelling down the address pipe
  typedef struct packed {
    logic             valid;
    logic             write;
    logic             last;
    logic [BIT_W-1:0] bit_idx;
    logic [1:0]       dx;
    logic [1:0]       dy;
    logic [1:0]       dz;
  } step_t;

endpackage

// File: hdl/vnm_ram.sv
// Generic single-port RAM with registered read.
module vnm_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hdl/vnm_nbr.sv
// Neighbour address generator: chunk split, world bounds and store address.
module vnm_nbr #(
  parameter int CHUNK_SPAN_X  = 16,
  parameter int CHUNK_SPAN_Z  = 16,
  parameter int COLUMN_HEIGHT = 16,
  parameter int CHUNK_COUNT_X = 4,
  parameter int CHUNK_COUNT_Z = 4,
  localparam int CPC    = CHUNK_SPAN_X * CHUNK_SPAN_Z * COLUMN_HEIGHT,
  localparam int CELLS  = CPC * CHUNK_COUNT_X * CHUNK_COUNT_Z,
  localparam int ADDR_W = $clog2(CELLS)
) (
  input  logic               clk,
  input  logic               rst,
  input  vnm_pkg::step_t     step_in,
  input  vnm_pkg::pos_t      pos,
  output vnm_pkg::step_t     step_out,
  output logic               hit,
  output logic [ADDR_W-1:0]  addr
);

  localparam int WORLD_X = CHUNK_SPAN_X * CHUNK_COUNT_X;
  localparam int WORLD_Z = CHUNK_SPAN_Z * CHUNK_COUNT_Z;
  localparam int LXW     = $clog2(CHUNK_SPAN_X);
  localparam int LZW     = $clog2(CHUNK_SPAN_Z);
  localparam int CXW     = $clog2(CHUNK_COUNT_X + 1);
  localparam int CZW     = $clog2(CHUNK_COUNT_Z + 1);
  localparam int YW      = vnm_pkg::POS_Y_W + 1;
  localparam int XZ_N    = 1 << vnm_pkg::POS_XZ_W;
  localparam int LAYER   = CHUNK_SPAN_X * CHUNK_SPAN_Z;
  localparam int ROW_Z   = CHUNK_COUNT_X * CPC;

  // coordinate split tables (chunk, local, in range)
  logic [CXW-1:0] xt_chunk [XZ_N];
  logic [LXW-1:0] xt_local [XZ_N];
  logic           xt_in    [XZ_N];
  logic [CZW-1:0] zt_chunk [XZ_N];
  logic [LZW-1:0] zt_local [XZ_N];
  logic           zt_in    [XZ_N];

  for (genvar g = 0; g < XZ_N; g++) begin : g_split
    localparam int GCX = g / CHUNK_SPAN_X;
    localparam int GLX = g % CHUNK_SPAN_X;
    localparam int GCZ = g / CHUNK_SPAN_Z;
    localparam int GLZ = g % CHUNK_SPAN_Z;
    assign xt_chunk[g] = CXW'(GCX);
    assign xt_local[g] = LXW'(GLX);
    assign xt_in[g]    = (g < WORLD_X);
    assign zt_chunk[g] = CZW'(GCZ);
    assign zt_local[g] = LZW'(GLZ);
    assign zt_in[g]    = (g < WORLD_Z);
  end

  logic [CXW-1:0] cx, ncx;
  logic [LXW-1:0] lx, nlx;
  logic [CZW-1:0] cz, ncz;
  logic [LZW-1:0] lz, nlz;
  logic [YW-1:0]  ny;
  logic           q_in, x_ok, z_ok, y_ok, x_cross, z_cross, hit_next;

  always_comb begin
    cx   = xt_chunk[pos.x];
    lx   = xt_local[pos.x];
    cz   = zt_chunk[pos.z];
    lz   = zt_local[pos.z];
    q_in = xt_in[pos.x] && zt_in[pos.z] && (int'(pos.y) < COLUMN_HEIGHT);

    ncx = cx; nlx = lx; x_ok = 1'b1; x_cross = 1'b0;
    case (step_in.dx)
      vnm_pkg::OFS_MINUS: begin
        if (lx == '0) begin
          if (cx == '0) begin
            x_ok = 1'b0;
          end else begin
            ncx = cx - 1'b1; nlx = LXW'(CHUNK_SPAN_X - 1); x_cross = 1'b1;
          end
        end else begin
          nlx = lx - 1'b1;
        end
      end
      vnm_pkg::OFS_ZERO: ;
      vnm_pkg::OFS_PLUS: begin
        if (lx == LXW'(CHUNK_SPAN_X - 1)) begin
          if (cx == CXW'(CHUNK_COUNT_X - 1)) begin
            x_ok = 1'b0;
          end else begin
            ncx = cx + 1'b1; nlx = '0; x_cross = 1'b1;
          end
        end else begin
          nlx = lx + 1'b1;
        end
      end
      default: x_ok = 1'b0;
    endcase

    ncz = cz; nlz = lz; z_ok = 1'b1; z_cross = 1'b0;
    case (step_in.dz)
      vnm_pkg::OFS_MINUS: begin
        if (lz == '0) begin
          if (cz == '0) begin
            z_ok = 1'b0;
          end else begin
            ncz = cz - 1'b1; nlz = LZW'(CHUNK_SPAN_Z - 1); z_cross = 1'b1;
          end
        end else begin
          nlz = lz - 1'b1;
        end
      end
      vnm_pkg::OFS_ZERO: ;
      vnm_pkg::OFS_PLUS: begin
        if (lz == LZW'(CHUNK_SPAN_Z - 1)) begin
          if (cz == CZW'(CHUNK_COUNT_Z - 1)) begin
            z_ok = 1'b0;
          end else begin
            ncz = cz + 1'b1; nlz = '0; z_cross = 1'b1;
          end
        end else begin
          nlz = lz + 1'b1;
        end
      end
      default: z_ok = 1'b0;
    endcase

    ny   = {1'b0, pos.y};
    y_ok = 1'b1;
    case (step_in.dy)
      vnm_pkg::OFS_MINUS: begin
        if (pos.y == '0) begin
          y_ok = 1'b0;
        end else begin
          ny = {1'b0, pos.y} - 1'b1;
        end
      end
      vnm_pkg::OFS_ZERO: ;
      vnm_pkg::OFS_PLUS: ny = {1'b0, pos.y} + 1'b1;
      default: y_ok = 1'b0;
    endcase
    y_ok = y_ok && (int'(ny) < COLUMN_HEIGHT);

    // diagonal across both an x and a z chunk seam is not counted
    hit_next = q_in && x_ok && y_ok && z_ok && !(x_cross && z_cross);
  end

  // stage 1: neighbour coordinates
  vnm_pkg::step_t s1;
  logic           s1_hit;
  logic [CXW-1:0] s1_cx;
  logic [LXW-1:0] s1_lx;
  logic [CZW-1:0] s1_cz;
  logic [LZW-1:0] s1_lz;
  logic [YW-1:0]  s1_y;

  // stage 2: chunk base and offset within chunk
  logic [ADDR_W-1:0] base, loc_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1       <= '0;
      step_out <= '0;
    end else begin
      s1       <= step_in;
      step_out <= s1;
    end
  end

  always_ff @(posedge clk) begin
    s1_hit  <= hit_next;
    s1_cx   <= ncx;
    s1_lx   <= nlx;
    s1_cz   <= ncz;
    s1_lz   <= nlz;
    s1_y    <= ny;
    hit     <= s1_hit;
    base    <= ADDR_W'(s1_cz) * ADDR_W'(ROW_Z) + ADDR_W'(s1_cx) * ADDR_W'(CPC);
    loc_off <= ADDR_W'(s1_y) * ADDR_W'(LAYER) + ADDR_W'(s1_lz) * ADDR_W'(CHUNK_SPAN_X)
             + ADDR_W'(s1_lx);
  end

  assign addr = base + loc_off;

endmodule

// File: hdl/voxel_neighbour_mask.sv
// Top level: voxel store with 3x3x3 occupancy query.
//
//  channel   handshake                 carries
//  config    cfg_write                 cfg_data -> bottom_fill_mask
//  input     in_valid / in_ready       operation, pos_x, pos_y, pos_z, new_type
//  output    out_valid / out_ready     cell_type, neighbour_mask
//
// After reset a clearing pass zeroes the store, all CELLS voxels (65536 at
// the defaults), one voxel a cycle; no word is taken meanwhile.
// A query makes 27 reads from the single-port store, one per cycle, which
// pass through the address pipe and the registered read before the result
// is handed over. A write makes a single store access at the centre.
// One word is worked on at a time; the next is taken while a result waits
// in the output register, and a finished query holds until that register frees.
module voxel_neighbour_mask #(
  parameter int CHUNK_SPAN_X  = 16,
  parameter int CHUNK_SPAN_Z  = 16,
  parameter int COLUMN_HEIGHT = 16,
  parameter int CHUNK_COUNT_X = 4,
  parameter int CHUNK_COUNT_Z = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [vnm_pkg::MASK_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               operation,
  input  logic [vnm_pkg::POS_XZ_W-1:0]       pos_x,
  input  logic [vnm_pkg::POS_Y_W-1:0]        pos_y,
  input  logic [vnm_pkg::POS_XZ_W-1:0]       pos_z,
  input  logic [vnm_pkg::TYPE_W-1:0]         new_type,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [vnm_pkg::TYPE_W-1:0]         cell_type,
  output logic [vnm_pkg::MASK_W-1:0]         neighbour_mask
);

`include "assert_macros.svh"

  localparam int CPC   = CHUNK_SPAN_X * CHUNK_SPAN_Z * COLUMN_HEIGHT;
  localparam int CELLS = CPC * CHUNK_COUNT_X * CHUNK_COUNT_Z;
  localparam int AW    = $clog2(CELLS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                   state;
  logic [AW-1:0]                clr_addr;
  vnm_pkg::step_t               step, step_adv;
  vnm_pkg::pos_t                pos;
  logic [vnm_pkg::TYPE_W-1:0]   wtype;
  logic [vnm_pkg::MASK_W-1:0]   bottom_fill_mask;
  logic [vnm_pkg::MASK_W-1:0]   acc_mask;
  logic [vnm_pkg::TYPE_W-1:0]   centre_type;
  logic                         centre_in;

  // read tag, lined up with the store's read data
  logic                         r_valid, r_last, r_hit;
  logic [vnm_pkg::BIT_W-1:0]    r_bit;

  vnm_pkg::step_t               nbr_step;
  logic                         nbr_hit;
  logic [AW-1:0]                nbr_addr;

  logic                         clearing, out_load;
  logic                         ram_we;
  logic [AW-1:0]                ram_addr;
  logic [vnm_pkg::TYPE_W-1:0]   ram_wdata, ram_rdata;

  assign in_ready = (state == ST_IDLE);
  assign clearing = (state == ST_CLEAR);
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // walk dx fastest, then dz, then dy: bit index is the step count
  always_comb begin
    step_adv         = step;
    step_adv.bit_idx = step.bit_idx + 1'b1;
    step_adv.last    = (step_adv.bit_idx == vnm_pkg::LAST_BIT);
    if (step.dx == vnm_pkg::OFS_PLUS) begin
      step_adv.dx = vnm_pkg::OFS_MINUS;
      if (step.dz == vnm_pkg::OFS_PLUS) begin
        step_adv.dz = vnm_pkg::OFS_MINUS;
        step_adv.dy = step.dy + 1'b1;
      end else begin
        step_adv.dz = step.dz + 1'b1;
      end
    end else begin
      step_adv.dx = step.dx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      clr_addr         <= '0;
      step             <= '0;
      out_valid        <= 1'b0;
      r_valid          <= 1'b0;
      bottom_fill_mask <= vnm_pkg::BOTTOM_RESET;
    end else begin
      if (cfg_write) begin
        bottom_fill_mask <= cfg_data;
      end
      r_valid <= nbr_step.valid && !nbr_step.write;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_ISSUE;
            if (operation == vnm_pkg::OP_WRITE) begin
              // single access at the centre
              step <= '{valid: 1'b1, write: 1'b1, last: 1'b1,
                        bit_idx: vnm_pkg::CENTRE_BIT, dx: vnm_pkg::OFS_ZERO,
                        dy: vnm_pkg::OFS_ZERO, dz: vnm_pkg::OFS_ZERO};
            end else begin
              step <= '{valid: 1'b1, write: 1'b0, last: 1'b0,
                        bit_idx: '0, dx: vnm_pkg::OFS_MINUS,
                        dy: vnm_pkg::OFS_MINUS, dz: vnm_pkg::OFS_MINUS};
            end
          end
        end
        ST_ISSUE: begin
          if (step.last) begin
            step.valid <= 1'b0;
            state      <= ST_DRAIN;
          end else begin
            step <= step_adv;
          end
        end
        ST_DRAIN: begin
          if (nbr_step.valid && nbr_step.write) begin
            state <= ST_IDLE;
          end else if (r_valid && r_last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    r_last <= nbr_step.last;
    r_hit  <= nbr_hit;
    r_bit  <= nbr_step.bit_idx;
    if (in_valid && in_ready) begin
      pos      <= '{x: pos_x, y: pos_y, z: pos_z};
      wtype    <= new_type;
      acc_mask <= '0;
    end else if (r_valid && r_hit && ram_rdata != '0) begin
      acc_mask[r_bit] <= 1'b1;
    end
    if (r_valid && r_bit == vnm_pkg::CENTRE_BIT) begin
      centre_type <= r_hit ? ram_rdata : '0;
      centre_in   <= r_hit;
    end
    if (out_load) begin
      cell_type      <= centre_type;
      // bottom layer forcing only for a voxel inside the world
      neighbour_mask <= acc_mask | ((centre_in && pos.y == '0) ? bottom_fill_mask : '0);
    end
  end

  vnm_nbr #(
    .CHUNK_SPAN_X  (CHUNK_SPAN_X),
    .CHUNK_SPAN_Z  (CHUNK_SPAN_Z),
    .COLUMN_HEIGHT (COLUMN_HEIGHT),
    .CHUNK_COUNT_X (CHUNK_COUNT_X),
    .CHUNK_COUNT_Z (CHUNK_COUNT_Z)
  ) u_nbr (
    .clk      (clk),
    .rst      (rst),
    .step_in  (step),
    .pos      (pos),
    .step_out (nbr_step),
    .hit      (nbr_hit),
    .addr     (nbr_addr)
  );

  // clearing pass owns the port until done
  assign ram_we    = clearing || (nbr_step.valid && nbr_step.write && nbr_hit);
  assign ram_addr  = clearing ? clr_addr : nbr_addr;
  assign ram_wdata = clearing ? '0 : wtype;

  vnm_ram #(
    .WIDTH (vnm_pkg::TYPE_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  `ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, state == ST_ISSUE,
               "accepted word did not start issuing")
  `ASSERT_IMPL(a_read_in_flight, clk, rst, r_valid, state == ST_ISSUE || state == ST_DRAIN,
               "read data returned outside a query")
  `ASSERT_IMPL(a_write_alone, clk, rst, nbr_step.valid && nbr_step.write, !r_valid,
               "store write overlaps query reads")
  `ASSERT_IMPL(a_offset_code, clk, rst, step.valid,
               step.dx != vnm_pkg::OFS_NONE && step.dy != vnm_pkg::OFS_NONE
               && step.dz != vnm_pkg::OFS_NONE,
               "offset counter out of range")
  `ASSERT_IMPL(a_out_from_done, clk, rst, $rose(out_valid), $past(state) == ST_DONE,
               "result shown without a finished query")

endmodule

// File: sim/voxel_neighbour_mask_test.sv
// Self-checking bench for the voxel neighbour mask: directed and clustered random words.
module voxel_neighbour_mask_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MASK_W   = vnm_pkg::MASK_W;
  localparam int POS_XZ_W = vnm_pkg::POS_XZ_W;
  localparam int POS_Y_W  = vnm_pkg::POS_Y_W;
  localparam int TYPE_W   = vnm_pkg::TYPE_W;
  localparam logic OP_WRITE = vnm_pkg::OP_WRITE;
  localparam logic OP_QUERY = vnm_pkg::OP_QUERY;
  localparam logic [MASK_W-1:0] BOTTOM_RESET = vnm_pkg::BOTTOM_RESET;

  // Geometry; the block is built with the same values.
  localparam int SPAN_X      = 16;
  localparam int SPAN_Z      = 16;
  localparam int HEIGHT      = 16;
  localparam int COUNT_X     = 4;
  localparam int COUNT_Z     = 4;
  localparam int WORLD_X     = SPAN_X * COUNT_X;
  localparam int WORLD_Z     = SPAN_Z * COUNT_Z;
  localparam int CHUNK_CELLS = SPAN_X * SPAN_Z * HEIGHT;
  localparam int STORE_CELLS = CHUNK_CELLS * COUNT_X * COUNT_Z;

  // Wait long enough for a query or a write to finish, with slack on top.
  localparam int SETTLE_CYCLES  = 40;
  // Must cover the clearing pass after reset (one voxel a cycle).
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int REPORT_LIMIT   = 10;
  localparam int HOLD_CYCLES    = 400;
  localparam int ROUND_WORDS    = 420;

  localparam logic [MASK_W-1:0] MASK_ALL = {MASK_W{1'b1}};

  // one input word
  typedef struct packed {
    logic                op;
    logic [POS_XZ_W-1:0] x;
    logic [POS_Y_W-1:0]  y;
    logic [POS_XZ_W-1:0] z;
    logic [TYPE_W-1:0]   block_type;
  } voxel_word_t;

  // one result word
  typedef struct packed {
    logic [TYPE_W-1:0] voxel_kind;
    logic [MASK_W-1:0] occupancy;
  } occupancy_t;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_PERIODIC} ready_style_e;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                cfg_write      = 1'b0;
  logic [MASK_W-1:0]   cfg_data       = '0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic                operation      = OP_WRITE;
  logic [POS_XZ_W-1:0] pos_x          = '0;
  logic [POS_Y_W-1:0]  pos_y          = '0;
  logic [POS_XZ_W-1:0] pos_z          = '0;
  logic [TYPE_W-1:0]   new_type       = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [TYPE_W-1:0]   cell_type;
  logic [MASK_W-1:0]   neighbour_mask;

  // Mirror of the block: voxel types and the bottom fill register.
  bit   [TYPE_W-1:0]   voxel_mirror [STORE_CELLS];
  logic [MASK_W-1:0]   bottom_fill = BOTTOM_RESET;
  occupancy_t          pending_occupancy [$];
  int                  mismatches = 0;

  // sender burst state
  int burst_left = 0;

  // receiver stall state; hold_request asks for one long hold-off
  int           hold_request = 0;
  int           hold_left    = 0;
  int           style_left   = 0;
  int           ready_phase  = 0;
  ready_style_e ready_style  = READY_ALWAYS;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  voxel_neighbour_mask #(
    .CHUNK_SPAN_X  (SPAN_X),
    .CHUNK_SPAN_Z  (SPAN_Z),
    .COLUMN_HEIGHT (HEIGHT),
    .CHUNK_COUNT_X (COUNT_X),
    .CHUNK_COUNT_Z (COUNT_Z)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .new_type       (new_type),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cell_type      (cell_type),
    .neighbour_mask (neighbour_mask)
  );

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic bit in_world(int x, int y, int z);
    return x >= 0 && x < WORLD_X && y >= 0 && y < HEIGHT && z >= 0 && z < WORLD_Z;
  endfunction

  // chunk-major layout (chunk z, then x); inside a chunk y, then z, then x
  function automatic int voxel_addr(int x, int y, int z);
    int chunk;
    chunk = (z / SPAN_Z) * COUNT_X + x / SPAN_X;
    return chunk * CHUNK_CELLS + (y * SPAN_Z + z % SPAN_Z) * SPAN_X + x % SPAN_X;
  endfunction

  function automatic occupancy_t predict_occupancy(int x, int y, int z);
    occupancy_t r;
    int         nx, ny, nz;
    bit         x_cross, z_cross;
    r = '0;
    // off-world query: empty word, no bottom fill
    if (!in_world(x, y, z))
      return r;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dz = -1; dz <= 1; dz++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          nx = x + dx;
          ny = y + dy;
          nz = z + dz;
          if (!in_world(nx, ny, nz))
            continue;
          // diagonal across both an x and a z chunk seam is never counted
          x_cross = (nx / SPAN_X) != (x / SPAN_X);
          z_cross = (nz / SPAN_Z) != (z / SPAN_Z);
          if (x_cross && z_cross)
            continue;
          if (voxel_mirror[voxel_addr(nx, ny, nz)] != '0)
            r.occupancy[(dy + 1) * 9 + (dz + 1) * 3 + (dx + 1)] = 1'b1;
        end
      end
    end
    if (y == 0)
      r.occupancy |= bottom_fill;
    r.voxel_kind = voxel_mirror[voxel_addr(x, y, z)];
    return r;
  endfunction

  // Applied once per accepted word, in acceptance order.
  function automatic void take_word(voxel_word_t w);
    if (w.op == OP_WRITE) begin
      if (in_world(w.x, w.y, w.z))
        voxel_mirror[voxel_addr(w.x, w.y, w.z)] = w.block_type;
    end else begin
      pending_occupancy.push_back(predict_occupancy(w.x, w.y, w.z));
    end
  endfunction

  // ---------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------

  function automatic voxel_word_t make_word(logic op, logic [POS_XZ_W-1:0] x,
                                            logic [POS_Y_W-1:0] y, logic [POS_XZ_W-1:0] z,
                                            logic [TYPE_W-1:0] t);
    voxel_word_t w;
    w.op         = op;
    w.x          = x;
    w.y          = y;
    w.z          = z;
    w.block_type = t;
    return w;
  endfunction

  function automatic voxel_word_t random_word();
    return make_word(logic'($urandom_range(0, 1)), POS_XZ_W'($urandom),
                     POS_Y_W'($urandom), POS_XZ_W'($urandom), TYPE_W'($urandom));
  endfunction

  // biased towards chunk seams, where the crossing rule bites
  function automatic logic [POS_XZ_W-1:0] pick_xz(int span, int count);
    int lo;
    lo = $urandom_range(0, 1);
    case ($urandom_range(0, 3))
      0:       return POS_XZ_W'($urandom_range(0, count - 1) * span + lo);
      1:       return POS_XZ_W'($urandom_range(1, count) * span - 1 - lo);
      default: return POS_XZ_W'($urandom);
    endcase
  endfunction

  // bottom and top layers get extra weight
  function automatic logic [POS_Y_W-1:0] pick_y();
    case ($urandom_range(0, 3))
      0:       return POS_Y_W'($urandom_range(0, 1));
      1:       return POS_Y_W'(HEIGHT - 1 - $urandom_range(0, 1));
      default: return POS_Y_W'($urandom);
    endcase
  endfunction

  // one step either way; wraps across the world edge, which stays in range
  function automatic logic [POS_XZ_W-1:0] near_xz(logic [POS_XZ_W-1:0] c);
    return c + POS_XZ_W'($urandom_range(0, 2)) - POS_XZ_W'(1);
  endfunction

  function automatic logic [POS_Y_W-1:0] near_y(logic [POS_Y_W-1:0] c);
    return c + POS_Y_W'($urandom_range(0, 2)) - POS_Y_W'(1);
  endfunction

  // a fair share of empties so voxels get cleared again
  function automatic logic [TYPE_W-1:0] pick_type();
    if ($urandom_range(0, 3) == 0)
      return '0;
    return TYPE_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------
  // Sender, drain and register write
  // ---------------------------------------------------------------------

  // Offers one word and returns at the edge where it is taken. Valid is
  // only dropped when a gap starts, so back-to-back words keep it high.
  task automatic send_word(input voxel_word_t w);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 4);
        2:       gap = $urandom_range(5, 40);
        default: gap = $urandom_range(1, 12);
      endcase
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= w.op;
    pos_x      <= w.x;
    pos_y      <= w.y;
    pos_z      <= w.z;
    new_type   <= w.block_type;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    take_word(w);
  endtask

  // Wait for every result, then let a trailing write finish as well.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_occupancy.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register is only touched with the block idle.
  task automatic set_bottom_mask(input logic [MASK_W-1:0] value);
    drain_results();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    bottom_fill = value;
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Freshly cleared store: only the reset bottom fill shows.
  task automatic test_empty_store();
    send_word(make_word(OP_QUERY, '0, '0, '0, '0));
    send_word(make_word(OP_QUERY, '1, '1, '1, '1));
    send_word(make_word(OP_QUERY, '0, '1, '1, TYPE_W'($urandom)));
    send_word(make_word(OP_QUERY, '1, '0, '0, TYPE_W'($urandom)));
  endtask

  // Four chunks meet at x = 16, z = 16; diagonal neighbours across both
  // seams must not appear.
  task automatic test_chunk_corner();
    send_word(make_word(OP_WRITE, 6'd15, 4'd5, 6'd15, 5'd31));
    send_word(make_word(OP_WRITE, 6'd16, 4'd5, 6'd15, 5'd1));
    send_word(make_word(OP_WRITE, 6'd15, 4'd5, 6'd16, 5'd2));
    send_word(make_word(OP_WRITE, 6'd16, 4'd5, 6'd16, 5'd16));
    send_word(make_word(OP_WRITE, 6'd17, 4'd6, 6'd17, 5'd8));
    send_word(make_word(OP_WRITE, 6'd16, 4'd4, 6'd16, 5'd4));
    send_word(make_word(OP_QUERY, 6'd16, 4'd5, 6'd16, '0));
    send_word(make_word(OP_QUERY, 6'd15, 4'd5, 6'd15, '0));
    send_word(make_word(OP_QUERY, 6'd16, 4'd5, 6'd15, '0));
    // writing empty clears the voxel again
    send_word(make_word(OP_WRITE, 6'd16, 4'd5, 6'd16, 5'd0));
    send_word(make_word(OP_QUERY, 6'd16, 4'd5, 6'd16, '1));
  endtask

  // Corners of the world and cells beside them: neighbours beyond the edge are not counted.
  task automatic test_world_bounds();
    send_word(make_word(OP_WRITE, '1, '1, '1, 5'd31));
    send_word(make_word(OP_WRITE, '0, '0, '0, 5'd17));
    send_word(make_word(OP_WRITE, 6'd1, 4'd1, 6'd1, 5'd3));
    send_word(make_word(OP_QUERY, '1, '1, '1, '0));
    send_word(make_word(OP_QUERY, '0, '0, '0, '0));
    send_word(make_word(OP_QUERY, 6'd1, 4'd0, 6'd1, '0));
    send_word(make_word(OP_QUERY, 6'd62, 4'd14, 6'd62, '0));
  endtask

  // Bottom fill register at its extremes and in between; only y = 0 uses it.
  task automatic test_bottom_mask();
    logic [MASK_W-1:0] value;
    for (int i = 0; i < 4; i++) begin
      case (i)
        0:       value = '0;
        1:       value = MASK_ALL;
        2:       value = 27'h2AAAAAA;
        default: value = MASK_W'($urandom);
      endcase
      set_bottom_mask(value);
      send_word(make_word(OP_QUERY, '0, '0, '0, '0));
      send_word(make_word(OP_WRITE, pick_xz(SPAN_X, COUNT_X), '0, pick_xz(SPAN_Z, COUNT_Z),
                          pick_type()));
      send_word(make_word(OP_QUERY, pick_xz(SPAN_X, COUNT_X), '0, pick_xz(SPAN_Z, COUNT_Z),
                          '0));
      send_word(make_word(OP_QUERY, 6'd1, 4'd1, 6'd1, '0));
    end
  endtask

  // Receiver holds off for a long stretch while queries keep coming, so
  // the result register fills and the block stops taking words.
  task automatic test_output_backpressure();
    set_bottom_mask(BOTTOM_RESET);
    hold_request = HOLD_CYCLES;
    repeat (40)
      send_word(make_word(OP_QUERY, near_xz(6'd16), near_y(4'd5), near_xz(6'd16),
                          TYPE_W'($urandom)));
  endtask

  // Mostly clusters: a few writes around a centre, then queries next to
  // it, so masks come out well populated. The rest is loose noise.
  task automatic test_clustered_random();
    int                  sent;
    logic [POS_XZ_W-1:0] cx, cz;
    logic [POS_Y_W-1:0]  cy;
    for (int round = 0; round < 4; round++) begin
      case (round)
        0:       set_bottom_mask(BOTTOM_RESET);
        1:       set_bottom_mask(MASK_W'($urandom));
        2:       set_bottom_mask(MASK_ALL);
        default: set_bottom_mask('0);
      endcase
      sent = 0;
      while (sent < ROUND_WORDS) begin
        if ($urandom_range(0, 6) == 0) begin
          send_word(random_word());
          sent++;
        end else begin
          cx = pick_xz(SPAN_X, COUNT_X);
          cy = pick_y();
          cz = pick_xz(SPAN_Z, COUNT_Z);
          repeat ($urandom_range(2, 10)) begin
            send_word(make_word(OP_WRITE, near_xz(cx), near_y(cy), near_xz(cz), pick_type()));
            sent++;
          end
          repeat ($urandom_range(1, 4)) begin
            send_word(make_word(OP_QUERY, near_xz(cx), near_y(cy), near_xz(cz),
                                TYPE_W'($urandom)));
            sent++;
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: switches between stall styles, or holds off on request
  // ---------------------------------------------------------------------

  always @(posedge clk) begin : receiver
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        ready_style = ready_style_e'($urandom_range(0, 3));
        style_left  = $urandom_range(16, 160);
      end
      style_left--;
      ready_phase++;
      case (ready_style)
        READY_ALWAYS:   out_ready <= 1'b1;
        READY_COIN:     out_ready <= logic'($urandom_range(0, 1));
        READY_MOSTLY:   out_ready <= ($urandom_range(0, 4) != 0);
        READY_PERIODIC: out_ready <= (ready_phase % 7) < 3;
        default:        out_ready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Result check against the oldest expectation
  // ---------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    occupancy_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_occupancy.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result cell_type=%0d neighbour_mask=%h",
                   $realtime, cell_type, neighbour_mask);
      end else begin
        want = pending_occupancy.pop_front();
        if (cell_type !== want.voxel_kind || neighbour_mask !== want.occupancy) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: mismatch cell_type exp %0d got %0d, neighbour_mask exp %h got %h",
                     $realtime, want.voxel_kind, cell_type, want.occupancy, neighbour_mask);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: too long without any word moving on either channel
  // ---------------------------------------------------------------------

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // first word waits out the clearing pass
    test_empty_store();
    test_chunk_corner();
    test_world_bounds();
    test_bottom_mask();
    test_output_backpressure();
    test_clustered_random();
    drain_results();
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
